// ===== hdl/gdm_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gdm_pkg: shared types and constants of the detection merge unit
// Beat layouts of both channels, field widths, register indexes and the
// reset values of the configuration registers.
// ----------------------------------------------------------------------------
package gdm_pkg;

	localparam int unsigned POS_W    = 11;
	localparam int unsigned RADIUS_W = 10;
	localparam int unsigned SCORE_W  = 16;
	localparam int unsigned TOL_W    = 11;
	localparam int unsigned CFG_W    = 16;

	// configuration register indexes
	localparam logic REG_SUPPRESSION_LIMIT  = 1'b0;
	localparam logic REG_DISTANCE_TOLERANCE = 1'b1;

	localparam logic [SCORE_W-1:0] SUPPRESSION_LIMIT_RST  = 16'd6554;
	localparam logic [TOL_W-1:0]   DISTANCE_TOLERANCE_RST = 11'd40;

	typedef struct packed {
		logic [POS_W-1:0]    pos_x;
		logic [POS_W-1:0]    pos_y;
		logic [RADIUS_W-1:0] circle_radius;
		logic [SCORE_W-1:0]  score;
		logic                last_in;
	} det_beat_t;

	typedef struct packed {
		logic [POS_W-1:0]    out_x;
		logic [POS_W-1:0]    out_y;
		logic [RADIUS_W-1:0] out_radius;
		logic [SCORE_W-1:0]  out_score;
		logic                last_out;
	} kept_beat_t;

endpackage

// ===== hdl/gdm_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gdm_ram: generic simple dual-port RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module gdm_ram #(
	parameter int unsigned WIDTH = 48,
	parameter int unsigned DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

// ===== hdl/greedy_detection_merge_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// greedy_detection_merge_unit: greedy merge of circular detections
// Loads a list of detections and, on the final one, runs greedy suppression
// passes over the stored list, emitting one kept detection per pass.
// ----------------------------------------------------------------------------
//
//  channel  | dir | handshake              | payload
//  ---------+-----+------------------------+----------------------------------
//  det      | in  | det_valid / det_ready  | gdm_pkg::det_beat_t
//  kept     | out | kept_valid / kept_ready| gdm_pkg::kept_beat_t
//  cfg      | in  | cfg_we (no wait)       | cfg_index, cfg_data
//
//  Sequence: a detection without last_in is only stored. The final beat
//  starts the merge: the tolerance is squared (TOL_SQ, TOL_ST), then each
//  pass fetches the head (HEAD_RD, HEAD_LD), tests every remaining entry
//  through RD, DX, MX, MY and CMP, and emits in EMIT. The single squarer and
//  the one RAM read port set the steps per entry. Reset clears the sequencer,
//  the entry count and the output valid flag; the entry RAM is not cleared,
//  only written entries are ever read. A stalled kept beat holds the merge at
//  the end of the next pass; det_ready is low for the whole merge.
//
module greedy_detection_merge_unit #(
	parameter int unsigned MAX_ENTRIES = 64,
	parameter int unsigned COORD_BITS  = 11
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   det_valid,
	output logic                   det_ready,
	input  gdm_pkg::det_beat_t     det,
	output logic                   kept_valid,
	input  logic                   kept_ready,
	output gdm_pkg::kept_beat_t    kept,
	input  logic                   cfg_we,
	input  logic                   cfg_index,
	input  logic [gdm_pkg::CFG_W-1:0] cfg_data
);

	localparam int unsigned AW    = $clog2(MAX_ENTRIES);
	localparam int unsigned CNT_W = $clog2(MAX_ENTRIES + 1);
	// squarer operand: covers coordinate differences and the tolerance
	localparam int unsigned SQ_W  = (COORD_BITS > gdm_pkg::TOL_W) ? COORD_BITS : gdm_pkg::TOL_W;

	typedef struct packed {
		logic [COORD_BITS-1:0]        x;
		logic [COORD_BITS-1:0]        y;
		logic [gdm_pkg::RADIUS_W-1:0] r;
		logic [gdm_pkg::SCORE_W-1:0]  s;
	} entry_t;

	// sequencer states
	localparam logic [3:0] ST_IDLE    = 4'd0;
	localparam logic [3:0] ST_TOL_SQ  = 4'd1;
	localparam logic [3:0] ST_TOL_ST  = 4'd2;
	localparam logic [3:0] ST_HEAD_RD = 4'd3;
	localparam logic [3:0] ST_HEAD_LD = 4'd4;
	localparam logic [3:0] ST_RD      = 4'd5;
	localparam logic [3:0] ST_DX      = 4'd6;
	localparam logic [3:0] ST_MX      = 4'd7;
	localparam logic [3:0] ST_MY      = 4'd8;
	localparam logic [3:0] ST_CMP     = 4'd9;
	localparam logic [3:0] ST_EMIT    = 4'd10;

	logic [3:0]                   state_q;
	logic [CNT_W-1:0]             count_q;   // entries loaded
	logic [CNT_W-1:0]             n_q;       // entries in the current pass
	logic [CNT_W-1:0]             i_q;       // entry under test
	logic [CNT_W-1:0]             k_q;       // entries kept for the next pass
	logic [gdm_pkg::SCORE_W-1:0]  limit_q;
	logic [gdm_pkg::TOL_W-1:0]    tol_q;
	logic [2*SQ_W-1:0]            tol2_q;
	logic [SQ_W-1:0]              diff_q;
	logic [2*SQ_W-1:0]            prod_q;
	logic [2*SQ_W-1:0]            dist_q;
	entry_t                       head_q;
	entry_t                       cur_q;
	logic                         kept_valid_q;
	gdm_pkg::kept_beat_t          kept_q;

	// RAM ports
	logic                         ram_we;
	logic [AW-1:0]                ram_waddr;
	entry_t                       ram_wdata;
	logic [AW-1:0]                ram_raddr;
	entry_t                       ram_rdata;

	logic                         det_acc;
	logic                         has_room;
	logic [CNT_W-1:0]             count_nxt;
	entry_t                       det_entry;
	logic [COORD_BITS-1:0]        dx_abs;
	logic [COORD_BITS-1:0]        dy_abs;
	logic [2*SQ_W:0]              dist_sum;
	logic                         is_near;
	logic                         keep;
	logic                         emit_ok;
	logic                         pass_done;

	assign det_ready = (state_q == ST_IDLE);
	assign det_acc   = det_valid && det_ready;
	assign has_room  = (count_q < CNT_W'(MAX_ENTRIES));
	assign count_nxt = has_room ? count_q + CNT_W'(1) : count_q;

	assign det_entry.x = COORD_BITS'(det.pos_x);
	assign det_entry.y = COORD_BITS'(det.pos_y);
	assign det_entry.r = det.circle_radius;
	assign det_entry.s = det.score;

	// absolute differences against the head
	assign dx_abs = (head_q.x > ram_rdata.x) ? head_q.x - ram_rdata.x : ram_rdata.x - head_q.x;
	assign dy_abs = (head_q.y > cur_q.y) ? head_q.y - cur_q.y : cur_q.y - head_q.y;

	assign dist_sum  = {1'b0, dist_q} + {1'b0, prod_q};
	assign is_near   = (dist_sum < {1'b0, tol2_q});
	assign keep      = !is_near && (cur_q.s < limit_q);
	assign emit_ok   = !kept_valid_q || kept_ready;
	assign pass_done = (i_q + CNT_W'(1) == n_q);

	// one write port: loading while idle, compaction while comparing
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = count_q[AW-1:0];
		ram_wdata = det_entry;
		if (state_q == ST_IDLE) begin
			ram_we = det_acc && has_room;
		end else if (state_q == ST_CMP) begin
			ram_we    = keep;
			ram_waddr = k_q[AW-1:0];
			ram_wdata = cur_q;
		end
	end

	assign ram_raddr = (state_q == ST_RD) ? i_q[AW-1:0] : '0;

	gdm_ram #(
		.WIDTH($bits(entry_t)),
		.DEPTH(MAX_ENTRIES)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= gdm_pkg::SUPPRESSION_LIMIT_RST;
			tol_q   <= gdm_pkg::DISTANCE_TOLERANCE_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				gdm_pkg::REG_SUPPRESSION_LIMIT: begin
					limit_q <= cfg_data[gdm_pkg::SCORE_W-1:0];
				end
				gdm_pkg::REG_DISTANCE_TOLERANCE: begin
					tol_q <= cfg_data[gdm_pkg::TOL_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	// sequencer and control counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			count_q      <= '0;
			n_q          <= '0;
			i_q          <= '0;
			k_q          <= '0;
			kept_valid_q <= 1'b0;
		end else begin
			// raise valid on a new kept beat, drop it once the beat is taken
			if ((state_q == ST_EMIT) && emit_ok) begin
				kept_valid_q <= 1'b1;
			end else if (kept_ready) begin
				kept_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (det_acc) begin
						count_q <= count_nxt;
						if (det.last_in) begin
							n_q     <= count_nxt;
							state_q <= ST_TOL_SQ;
						end
					end
				end
				ST_TOL_SQ: begin
					state_q <= ST_TOL_ST;
				end
				ST_TOL_ST: begin
					state_q <= ST_HEAD_RD;
				end
				ST_HEAD_RD: begin
					state_q <= ST_HEAD_LD;
				end
				ST_HEAD_LD: begin
					i_q     <= CNT_W'(1);
					k_q     <= '0;
					state_q <= (n_q == CNT_W'(1)) ? ST_EMIT : ST_RD;
				end
				ST_RD: begin
					state_q <= ST_DX;
				end
				ST_DX: begin
					state_q <= ST_MX;
				end
				ST_MX: begin
					state_q <= ST_MY;
				end
				ST_MY: begin
					state_q <= ST_CMP;
				end
				ST_CMP: begin
					if (keep) begin
						k_q <= k_q + CNT_W'(1);
					end
					i_q     <= i_q + CNT_W'(1);
					state_q <= pass_done ? ST_EMIT : ST_RD;
				end
				ST_EMIT: begin
					if (emit_ok) begin
						n_q <= k_q;
						if (k_q == '0) begin
							count_q <= '0;
							state_q <= ST_IDLE;
						end else begin
							state_q <= ST_HEAD_RD;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// datapath: one shared squarer fed through diff_q
	always_ff @(posedge clk) begin
		prod_q <= diff_q * diff_q;
		case (state_q)
			ST_IDLE: begin
				diff_q <= SQ_W'(tol_q);
			end
			ST_TOL_ST: begin
				tol2_q <= prod_q;
			end
			ST_HEAD_LD: begin
				head_q <= ram_rdata;
			end
			ST_DX: begin
				cur_q  <= ram_rdata;
				diff_q <= SQ_W'(dx_abs);
			end
			ST_MX: begin
				diff_q <= SQ_W'(dy_abs);
			end
			ST_MY: begin
				dist_q <= prod_q;
			end
			ST_EMIT: begin
				if (emit_ok) begin
					kept_q.out_x      <= gdm_pkg::POS_W'(head_q.x);
					kept_q.out_y      <= gdm_pkg::POS_W'(head_q.y);
					kept_q.out_radius <= head_q.r;
					kept_q.out_score  <= head_q.s;
					kept_q.last_out   <= (k_q == '0);
				end
			end
			default: begin
			end
		endcase
	end

	assign kept_valid = kept_valid_q;
	assign kept       = kept_q;

endmodule

// ===== hdl/gdm_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gdm_checker: port-level checks of the detection merge unit
// Watches the handshakes of both channels; bound to the top level.
// ----------------------------------------------------------------------------
module gdm_checker (
	input logic                clk,
	input logic                arst_n,
	input logic                det_valid,
	input logic                det_ready,
	input gdm_pkg::det_beat_t  det,
	input logic                kept_valid,
	input logic                kept_ready,
	input gdm_pkg::kept_beat_t kept
);

	// a final detection starts a merge: no beat taken next cycle
	a_busy_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		det_valid && det_ready && det.last_in |=> !det_ready)
		else $error("det_ready high right after a final detection");

	// a non-final kept beat means the merge is still running
	a_busy_mid_merge: assert property (@(posedge clk) disable iff (!arst_n)
		kept_valid && !kept.last_out |-> !det_ready)
		else $error("det_ready high while a merge is in progress");

	// the merge ends by presenting its final kept beat
	a_end_with_last: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(det_ready) |-> kept_valid && kept.last_out)
		else $error("merge ended without a final kept beat");

	// a stalled kept beat holds
	a_kept_hold: assert property (@(posedge clk) disable iff (!arst_n)
		kept_valid && !kept_ready |=> kept_valid && $stable(kept))
		else $error("kept beat changed while stalled");

endmodule

bind greedy_detection_merge_unit gdm_checker u_gdm_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.det_valid (det_valid),
	.det_ready (det_ready),
	.det       (det),
	.kept_valid(kept_valid),
	.kept_ready(kept_ready),
	.kept      (kept)
);

// ===== bench/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench of the greedy detection merge unit
// Feeds lists of circular detections through the det channel and checks every
// kept beat against a local greedy-suppression predictor. The bench runs
// several register settings, random gaps on the det side and random stalls on
// the kept side.
// ----------------------------------------------------------------------------
module tb;

	localparam int unsigned LIST_DEPTH  = 64;
	localparam int unsigned CYCLE_LIMIT = 400000;
	// idle margin after the final kept beat; the sequencer is idle by then
	localparam int unsigned SETTLE_CYCLES = 24;
	localparam int unsigned POS_MAX = (1 << gdm_pkg::POS_W) - 1;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b1;
	logic                 det_valid = 1'b0;
	logic                 det_ready;
	gdm_pkg::det_beat_t   det = '0;
	logic                 kept_valid;
	logic                 kept_ready = 1'b0;
	gdm_pkg::kept_beat_t  kept;
	logic                 cfg_we = 1'b0;
	logic                 cfg_index = gdm_pkg::REG_SUPPRESSION_LIMIT;
	logic [gdm_pkg::CFG_W-1:0] cfg_data = '0;

	greedy_detection_merge_unit #(
		.MAX_ENTRIES (LIST_DEPTH),
		.COORD_BITS  (gdm_pkg::POS_W)
	) i_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.det_valid  (det_valid),
		.det_ready  (det_ready),
		.det        (det),
		.kept_valid (kept_valid),
		.kept_ready (kept_ready),
		.kept       (kept),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data)
	);

	// ------------------------------------------------------------------------
	// Bench state
	// ------------------------------------------------------------------------
	gdm_pkg::det_beat_t   det_pending[$];   // detections waiting to be driven
	gdm_pkg::kept_beat_t  kept_expect[$];   // kept beats predicted, oldest first
	int unsigned          dets_queued = 0;
	int unsigned          dets_sent = 0;
	int unsigned          kept_seen = 0;
	int unsigned          mismatches = 0;
	int unsigned          cycle_count = 0;
	int unsigned          det_gap = 0;
	int unsigned          kept_wait = 0;
	bit                   det_calm = 1'b0;
	bit                   kept_calm = 1'b0;

	// local copy of the register file and of the detection list
	logic [gdm_pkg::SCORE_W-1:0] limit_cfg = gdm_pkg::SUPPRESSION_LIMIT_RST;
	logic [gdm_pkg::TOL_W-1:0]   tol_cfg = gdm_pkg::DISTANCE_TOLERANCE_RST;
	gdm_pkg::det_beat_t   merge_list[LIST_DEPTH];
	int unsigned          list_len = 0;
	bit                   list_overflow = 1'b0;

	initial begin
		forever #5 clk = ~clk;
	end

	// ------------------------------------------------------------------------
	// Predictor
	// ------------------------------------------------------------------------
	function automatic bit within_tolerance(gdm_pkg::det_beat_t a, gdm_pkg::det_beat_t b);
		int unsigned dx;
		int unsigned dy;
		int unsigned tol;
		dx  = (a.pos_x > b.pos_x) ? a.pos_x - b.pos_x : b.pos_x - a.pos_x;
		dy  = (a.pos_y > b.pos_y) ? a.pos_y - b.pos_y : b.pos_y - a.pos_y;
		tol = tol_cfg;
		return (dx * dx + dy * dy) < (tol * tol);
	endfunction

	// Store one accepted detection; on the final one run the greedy passes
	// and queue one kept beat per pass.
	task automatic absorb_detection(input gdm_pkg::det_beat_t b);
		int unsigned n;
		int unsigned k;
		int unsigned i;
		gdm_pkg::det_beat_t  head;
		gdm_pkg::kept_beat_t kb;
		if (list_len < LIST_DEPTH) begin
			merge_list[list_len] = b;
			list_len++;
		end else begin
			// full list: drop the detection, keep its last_in
			list_overflow = 1'b1;
		end
		if (!b.last_in)
			return;
		n = list_len;
		while (n > 0) begin
			head = merge_list[0];
			k = 0;
			for (i = 1; i < n; i++) begin
				// drop near entries, and far ones scoring at or above the limit
				if (!within_tolerance(head, merge_list[i]) &&
						merge_list[i].score < limit_cfg) begin
					merge_list[k] = merge_list[i];
					k++;
				end
			end
			n = k;
			kb.out_x      = head.pos_x;
			kb.out_y      = head.pos_y;
			kb.out_radius = head.circle_radius;
			kb.out_score  = head.score;
			kb.last_out   = (n == 0);
			kept_expect   = {kept_expect, kb};
		end
		list_len = 0;
		list_overflow = 1'b0;
	endtask

	task automatic report_mismatch(input string what);
		mismatches++;
		$display("[%0t] mismatch: %s", $realtime, what);
	endtask

	function automatic int unsigned draw_wait(input bit calm);
		return calm ? 0 : $urandom_range(0, 6);
	endfunction

	// ------------------------------------------------------------------------
	// Driver: present pending detections, one gap drawn per beat
	// ------------------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin
		bit        fire;
		bit        nxt_valid;
		if (!arst_n) begin
			det_valid <= 1'b0;
			det_gap = 0;
		end else begin
			fire = det_valid && det_ready;
			nxt_valid = det_valid;
			if (fire) begin
				absorb_detection(det);
				dets_sent++;
			end
			if (!det_valid || fire) begin
				if (det_gap > 0) begin
					det_gap--;
					nxt_valid = 1'b0;
				end else if (det_pending.size() > 0) begin
					det <= det_pending.pop_front();
					nxt_valid = 1'b1;
					det_gap = draw_wait(det_calm);
				end else begin
					nxt_valid = 1'b0;
				end
			end
			det_valid <= nxt_valid;
		end
	end

	// ------------------------------------------------------------------------
	// Monitor: check each kept beat, stall ready a drawn number of cycles
	// ------------------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin
		gdm_pkg::kept_beat_t want;
		bit         nxt_ready;
		if (!arst_n) begin
			kept_ready <= 1'b0;
			kept_wait = 0;
		end else begin
			nxt_ready = kept_ready;
			if (kept_valid && kept_ready) begin
				if (kept_expect.size() == 0) begin
					report_mismatch($sformatf("kept beat %0d arrived with none expected",
						kept_seen));
				end else begin
					want = kept_expect.pop_front();
					if (kept.out_x !== want.out_x)
						report_mismatch($sformatf("beat %0d out_x got %0d want %0d",
							kept_seen, kept.out_x, want.out_x));
					if (kept.out_y !== want.out_y)
						report_mismatch($sformatf("beat %0d out_y got %0d want %0d",
							kept_seen, kept.out_y, want.out_y));
					if (kept.out_radius !== want.out_radius)
						report_mismatch($sformatf("beat %0d out_radius got %0d want %0d",
							kept_seen, kept.out_radius, want.out_radius));
					if (kept.out_score !== want.out_score)
						report_mismatch($sformatf("beat %0d out_score got %0d want %0d",
							kept_seen, kept.out_score, want.out_score));
					if (kept.last_out !== want.last_out)
						report_mismatch($sformatf("beat %0d last_out got %0b want %0b",
							kept_seen, kept.last_out, want.last_out));
				end
				kept_seen++;
				kept_wait = draw_wait(kept_calm);
				nxt_ready = (kept_wait == 0);
			end else if (!kept_ready) begin
				if (kept_wait > 0)
					kept_wait--;
				nxt_ready = (kept_wait == 0);
			end
			kept_ready <= nxt_ready;
		end
	end

	// ------------------------------------------------------------------------
	// Watchdog
	// ------------------------------------------------------------------------
	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("timeout after %0d cycles, %0d kept beats outstanding",
			cycle_count, kept_expect.size());
		$display("== FAIL ==");
		$finish;
	end

	// ------------------------------------------------------------------------
	// Stimulus
	// ------------------------------------------------------------------------
	task automatic push_det(input int unsigned x, input int unsigned y,
			input int unsigned r, input int unsigned s, input bit last);
		gdm_pkg::det_beat_t b;
		b.pos_x         = gdm_pkg::POS_W'(x);
		b.pos_y         = gdm_pkg::POS_W'(y);
		b.circle_radius = gdm_pkg::RADIUS_W'(r);
		b.score         = gdm_pkg::SCORE_W'(s);
		b.last_in       = last;
		det_pending     = {det_pending, b};
		dets_queued++;
	endtask

	// Write a register; the block is idle whenever this is called.
	task automatic write_reg(input logic idx, input logic [gdm_pkg::CFG_W-1:0] val);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		cfg_we    <= 1'b0;
		if (idx == gdm_pkg::REG_SUPPRESSION_LIMIT)
			limit_cfg = val[gdm_pkg::SCORE_W-1:0];
		else
			tol_cfg = val[gdm_pkg::TOL_W-1:0];
	endtask

	// Wait until every detection is in and every kept beat is out (the sequencer
	// is idle by then), then wait out SETTLE_CYCLES as a margin.
	task automatic drain;
		while (dets_sent < dets_queued || kept_expect.size() > 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	function automatic int unsigned clamp_pos(input int v);
		if (v < 0)
			return 0;
		if (v > int'(POS_MAX))
			return POS_MAX;
		return v;
	endfunction

	// One list: most detections cluster around a center so that both the
	// near drop and the score test get exercised; the rest land anywhere.
	task automatic queue_random_list(input int unsigned len);
		int unsigned cx;
		int unsigned cy;
		int unsigned spread;
		int unsigned i;
		int unsigned x;
		int unsigned y;
		int unsigned s;
		cx = $urandom_range(0, POS_MAX);
		cy = $urandom_range(0, POS_MAX);
		spread = 2 * tol_cfg + 4;
		for (i = 0; i < len; i++) begin
			if ($urandom_range(0, 3) == 0) begin
				x = $urandom_range(0, POS_MAX);
				y = $urandom_range(0, POS_MAX);
			end else begin
				x = clamp_pos(int'(cx) + int'($urandom_range(0, 2 * spread)) - int'(spread));
				y = clamp_pos(int'(cy) + int'($urandom_range(0, 2 * spread)) - int'(spread));
			end
			case ($urandom_range(0, 3))
				0: s = $urandom_range(0, 65535);
				1: s = limit_cfg;
				default: s = (limit_cfg > 0) ? $urandom_range(0, limit_cfg - 1) :
					$urandom_range(0, 65535);
			endcase
			push_det(x, y, $urandom_range(0, 1023), s, i == len - 1);
		end
	endtask

	// Write both registers, pick the idling style and run random lists.
	task automatic run_setting(input logic [gdm_pkg::CFG_W-1:0] limit_val,
			input logic [gdm_pkg::CFG_W-1:0] tol_val, input bit calm,
			input int unsigned n_items, input bit with_full_list);
		int unsigned start;
		write_reg(gdm_pkg::REG_SUPPRESSION_LIMIT, limit_val);
		write_reg(gdm_pkg::REG_DISTANCE_TOLERANCE, tol_val);
		det_calm  = calm;
		kept_calm = calm;
		start = dets_queued;
		if (with_full_list)
			queue_random_list($urandom_range(LIST_DEPTH, LIST_DEPTH + 6));
		while (dets_queued - start < n_items)
			queue_random_list($urandom_range(1, 10));
		drain();
	endtask

	initial begin
		arst_n <= 1'b0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// Directed part, at reset values (limit 6554, tolerance 40).
		// single head with the worst score: still emitted
		push_det(POS_MAX, POS_MAX, 1023, 16'hFFFF, 1'b1);
		push_det(0, 0, 0, 0, 1'b1);
		// near, exactly on the tolerance, far good, far at the limit, far
		push_det(100, 100, 5, 16'hFFFF, 1'b0);
		push_det(110, 100, 6, 0, 1'b0);
		push_det(140, 100, 7, 0, 1'b0);
		push_det(1000, 1000, 8, 6553, 1'b0);
		push_det(1500, 1500, 9, 6554, 1'b0);
		push_det(0, 0, 10, 0, 1'b0);
		push_det(POS_MAX, 0, 1023, 1, 1'b1);
		// stacked duplicates collapse to one
		push_det(700, 300, 20, 10, 1'b0);
		push_det(700, 300, 21, 11, 1'b0);
		push_det(700, 300, 22, 12, 1'b1);
		// alternating bit patterns
		push_det(11'h555, 11'h2AA, 10'h2AA, 16'h5555, 1'b0);
		push_det(11'h2AA, 11'h555, 10'h155, 16'h0AAA, 1'b0);
		push_det(11'h7FF, 11'h000, 10'h3FF, 16'h1000, 1'b1);
		drain();

		// Random part over several register settings.
		run_setting(16'hFFFF, 16'd0, 1'b1, 45, 1'b0);
		run_setting(16'd0, {5'($urandom_range(0, 31)), 11'h7FF}, 1'b0, 45, 1'b0);
		run_setting(16'($urandom_range(1, 65534)), 16'($urandom_range(1, 200)), 1'b0, 45,
			1'b1);
		run_setting(16'd32768, 16'h07FF, 1'b0, 45, 1'b0);
		run_setting(gdm_pkg::SUPPRESSION_LIMIT_RST,
			gdm_pkg::CFG_W'(gdm_pkg::DISTANCE_TOLERANCE_RST), 1'b0, 45, 1'b1);

		if (kept_expect.size() != 0)
			report_mismatch($sformatf("%0d kept beats never arrived", kept_expect.size()));
		if (mismatches == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule

// ===== files.f =====
hdl/gdm_pkg.sv
hdl/gdm_ram.sv
hdl/greedy_detection_merge_unit.sv
hdl/gdm_checker.sv
bench/tb.sv
